>>> rtl/crc8_checked_frame_receiver_fifo_top_defines.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC8_CHECKED_FRAME_RECEIVER_FIFO_TOP_DEFINES_SVH
`define CRC8_CHECKED_FRAME_RECEIVER_FIFO_TOP_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define CFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define CFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/crc8cfr_pkg.sv
// Package with types, constants and the CRC-8 step for the frame receiver.
package crc8cfr_pkg;

    localparam int FRAME_BYTES    = 11;
    localparam int POS_W          = 4;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int CNT_OUT_W      = 5;
    localparam int STAT_W         = 16;
    localparam int OUT_W          = 128;

    localparam logic [7:0]        CRC_POLY = 8'h1D;
    localparam logic [7:0]        CRC_TOP  = 8'h80;
    localparam logic [STAT_W-1:0] CNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  check_byte;
        logic [31:0] payload;
        logic [31:0] timestamp;
        logic [7:0]  msg_id;
        logic [7:0]  node;
    } msg_t;

    typedef struct packed {
        logic load;
        logic pad;
        logic clear;
    } frm_ctrl_t;

    typedef struct packed {
        logic full;
        logic crc_ok;
    } frm_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_FINISH,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 8'h00)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/crc8cfr_msg_ram.sv
// Synchronous single-port-write, single-port-read message memory.
module crc8cfr_msg_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 88
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/crc8cfr_frame_asm.sv
// Frame byte collector with running CRC-8 and zero padding.
`include "crc8_checked_frame_receiver_fifo_top_defines.svh"

module crc8cfr_frame_asm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crc8cfr_pkg::frm_ctrl_t ctrl,
    input  logic [7:0]             rx_byte,
    output crc8cfr_pkg::frm_stat_t stat,
    output crc8cfr_pkg::msg_t      msg
);
    import crc8cfr_pkg::*;

    logic [7:0]       byte_reg [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       crc_reg;
    logic             room;

    assign room = (pos_reg < POS_W'(FRAME_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                byte_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                byte_reg[i] <= '0;
            end
        end
        else if (ctrl.load && room)
        begin
            pos_reg <= pos_reg + 1'b1;
            crc_reg <= crc8_byte(crc_reg, rx_byte);
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (pos_reg == POS_W'(i))
                begin
                    byte_reg[i] <= rx_byte;
                end
            end
        end
        else if (ctrl.pad && room)
        begin
            pos_reg <= pos_reg + 1'b1;
            crc_reg <= crc8_byte(crc_reg, 8'h00);
        end
    end

    assign stat.full   = !room;
    assign stat.crc_ok = (crc_reg == 8'h00);

    assign msg.node       = byte_reg[0];
    assign msg.msg_id     = byte_reg[1];
    assign msg.timestamp  = {byte_reg[5], byte_reg[4], byte_reg[3], byte_reg[2]};
    assign msg.payload    = {byte_reg[9], byte_reg[8], byte_reg[7], byte_reg[6]};
    assign msg.check_byte = byte_reg[10];

    `CFR_ASSERT_IMP(a_pos_in_range, clk, rst_n, 1'b1, pos_reg <= POS_W'(FRAME_BYTES), "frame position beyond frame length")
    `CFR_ASSERT_NXT(a_clear_resets, clk, rst_n, ctrl.clear, (pos_reg == '0) && (crc_reg == 8'h00), "frame state not cleared")

endmodule

>>> rtl/crc8_checked_frame_receiver_fifo_top.sv
// Top level of the CRC-8 checked frame receiver with message FIFO.
//
//  Channel   Direction  tdata                          tuser      tlast
//  s_axis    in         rx_byte                        func       frame_end
//  m_axis    out        message fields and counters    msg_valid  none
//
// A byte word without the end mark, and a pop, pass through accept and emit.
// A word with the end mark passes through accept, pad, finish and emit: the pad
// sequencer runs one CRC byte per cycle up to 11 bytes.
// Reset clears all control state; the message memory needs no clearing pass.
// A stalled output holds its word while the next input word is already accepted.
`include "crc8_checked_frame_receiver_fifo_top_defines.svh"

module crc8_checked_frame_receiver_fifo_top #(
    parameter int FIFO_DEPTH = crc8cfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // rx_byte
    input  logic                          s_axis_tuser,  // func
    input  logic                          s_axis_tlast,  // frame_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // node, msg_id, timestamp, payload, check_byte, fifo_count,
    // invalid_count, overflow_count, zero fill
    output logic [crc8cfr_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser   // msg_valid
);
    import crc8cfr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int MSG_W = $bits(msg_t);
    localparam int FILL_W = OUT_W - MSG_W - CNT_OUT_W - 2 * STAT_W;

    state_t state_reg, state_next;

    frm_ctrl_t frm_ctrl;
    frm_stat_t frm_stat;
    msg_t      frm_msg;
    msg_t      ram_rd_data;
    msg_t      emit_msg;

    logic in_acc;
    logic ram_wr;
    logic ram_rd;
    logic emit_go;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] bad_reg, bad_next;
    logic [STAT_W-1:0] drop_reg, drop_next;
    logic              hit_reg, hit_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    crc8cfr_frame_asm u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (frm_ctrl),
        .rx_byte (s_axis_tdata),
        .stat    (frm_stat),
        .msg     (frm_msg)
    );

    crc8cfr_msg_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (MSG_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (head_reg),
        .wr_data (frm_msg),
        .rd_en   (ram_rd),
        .rd_addr (tail_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (!s_axis_tuser && s_axis_tlast) ? ST_PAD : ST_EMIT;
                end
            end
            ST_PAD:
            begin
                if (frm_stat.full)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE);
        in_acc         = s_axis_tvalid && s_axis_tready;
        frm_ctrl.load  = in_acc && !s_axis_tuser;
        frm_ctrl.pad   = (state_reg == ST_PAD) && !frm_stat.full;
        frm_ctrl.clear = (state_reg == ST_FINISH);
        ram_rd         = in_acc && s_axis_tuser && (count_reg != '0);
        ram_wr         = (state_reg == ST_FINISH) && frm_stat.crc_ok
                         && (count_reg != CNT_W'(FIFO_DEPTH));
        emit_go        = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        drop_next  = drop_reg;
        hit_next   = in_acc ? ram_rd : hit_reg;

        if (ram_rd)
        begin
            tail_next  = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end

        if (state_reg == ST_FINISH)
        begin
            if (!frm_stat.crc_ok)
            begin
                if (bad_reg != CNT_MAX)
                begin
                    bad_next = bad_reg + 1'b1;
                end
            end
            else if (!ram_wr)
            begin
                if (drop_reg != CNT_MAX)
                begin
                    drop_next = drop_reg + 1'b1;
                end
            end
            else
            begin
                head_next  = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        emit_msg     = hit_reg ? ram_rd_data : '0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (emit_go)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {{FILL_W{1'b0}}, drop_reg, bad_reg, CNT_OUT_W'(count_reg), emit_msg};
            m_user_next  = hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            bad_reg     <= '0;
            drop_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            bad_reg     <= bad_next;
            drop_reg    <= drop_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `CFR_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ram_wr, !ram_rd, "memory read and write in one cycle")
    `CFR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "message count above depth")
    `CFR_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg, "empty queue with unequal pointers")
    `CFR_ASSERT_NXT(a_pop_count, clk, rst_n, ram_rd, count_reg == $past(count_reg) - 1'b1, "pop did not lower the count")

endmodule
